### hdl/lree_pkg.sv
// Shared types and constants for the LR expression evaluator.
`default_nettype none

package lree_pkg;

    // Stack sizing
    localparam int STACK_DEPTH = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);

    // Token kinds
    localparam logic [2:0] TK_INT   = 3'd0;
    localparam logic [2:0] TK_PLUS  = 3'd1;
    localparam logic [2:0] TK_TIMES = 3'd2;
    localparam logic [2:0] TK_OPEN  = 3'd3;
    localparam logic [2:0] TK_CLOSE = 3'd4;
    localparam logic [2:0] TK_END   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SYNTAX   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Parse table states
    localparam logic [3:0] PS_START      = 4'd0;
    localparam logic [3:0] PS_EXPR       = 4'd1;
    localparam logic [3:0] PS_OPEN       = 4'd2;
    localparam logic [3:0] PS_INT        = 4'd3;
    localparam logic [3:0] PS_PLUS       = 4'd4;
    localparam logic [3:0] PS_TIMES      = 4'd5;
    localparam logic [3:0] PS_PAREN_EXPR = 4'd6;
    localparam logic [3:0] PS_SUM        = 4'd7;
    localparam logic [3:0] PS_PROD       = 4'd8;
    localparam logic [3:0] PS_CLOSE      = 4'd9;

    // Input and result payloads
    typedef struct packed {
        logic [2:0]         token_kind;
        logic signed [31:0] token_value;
    } token_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] expr_value;
    } result_t;

    // Parser action for the current token and top state
    typedef enum logic [2:0] {
        ACT_SHIFT    = 3'd0,
        ACT_REDUCE   = 3'd1,
        ACT_ACCEPT   = 3'd2,
        ACT_OVERFLOW = 3'd3,
        ACT_ERROR    = 3'd4
    } action_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       shift;
        logic       read;
        logic       exec;
        logic       write;
        logic       finish;
        logic [1:0] fin_status;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        action_t action;
        logic    goto_err;
        logic    out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### hdl/lree_ctrl.sv
// Controller state machine that sequences shifts, reductions and results.
`default_nettype none

module lree_ctrl
    import lree_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_EXEC   = 4'b0100,
        S_WRITE  = 4'b1000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.fin_status = ST_SYNTAX;
        s_ready        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (status.action)
                    ACT_SHIFT: begin
                        cmd.shift  = 1'b1;
                        state_next = S_IDLE;
                    end
                    ACT_REDUCE: begin
                        cmd.read   = 1'b1;
                        state_next = S_EXEC;
                    end
                    default: begin
                        // terminal action: wait for a free output slot
                        if (status.action == ACT_ACCEPT) begin
                            cmd.fin_status = ST_OK;
                        end else if (status.action == ACT_OVERFLOW) begin
                            cmd.fin_status = ST_OVERFLOW;
                        end
                        if (status.out_free) begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE: begin
                if (status.goto_err) begin
                    if (status.out_free) begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    cmd.write  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/lree_datapath.sv
// Parse stack memories, top-of-stack registers, reduce unit and result register.
`default_nettype none

module lree_datapath
    import lree_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire token_t    s_data,
    input  wire ctrl_cmd_t cmd,
    output dp_status_t     status,
    output logic           m_valid,
    input  wire logic      m_ready,
    output result_t        m_data
);

    localparam logic [PTR_W-1:0] TOP_MAX = PTR_W'(STACK_DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);
    localparam logic [PTR_W-1:0] PTR_TWO = PTR_W'(2);
    localparam logic [PTR_W-1:0] PTR_THR = PTR_W'(3);

    // Stack memories; entry 0 is never written, and a read of it is replaced by the start state
    logic [3:0]  state_mem [STACK_DEPTH];
    logic [31:0] value_mem [STACK_DEPTH];

    // Current token
    logic [2:0]  kind_reg;
    logic [31:0] tval_reg;

    // Top of stack, cached
    logic [PTR_W-1:0] top_reg;
    logic [3:0]       tstate_reg;
    logic [31:0]      topval_reg;

    // Reduce pipeline
    logic [3:0]       op_reg;
    logic [3:0]       srd_reg;
    logic [31:0]      vrd_reg;
    logic             sbot_reg;
    logic [PTR_W-1:0] saddr_reg;
    logic [31:0]      rval_reg;
    logic [3:0]       goto_reg;
    logic             gerr_reg;
    logic [PTR_W-1:0] ntop_reg;

    // Result register
    logic    out_valid_reg;
    result_t out_data_reg;

    action_t          action;
    logic [3:0]       shift_st;
    logic             shift_ok;
    logic             reduce_ok;
    logic [PTR_W-1:0] saddr;
    logic [PTR_W-1:0] vaddr;
    logic [31:0]      rval;
    logic [3:0]       exposed_st;
    logic [3:0]       goto_st;
    logic             goto_bad;
    logic             mem_we;
    logic [PTR_W-1:0] waddr;
    logic [3:0]       wstate;
    logic [31:0]      wvalue;
    logic             ops_kind;

    // Parse table lookup on the top state and token
    always_comb begin
        shift_ok  = 1'b0;
        reduce_ok = 1'b0;
        shift_st  = PS_START;
        action    = ACT_ERROR;
        ops_kind  = (kind_reg == TK_PLUS) || (kind_reg == TK_TIMES) ||
                    (kind_reg == TK_CLOSE) || (kind_reg == TK_END);
        case (tstate_reg)
            PS_START, PS_OPEN, PS_PLUS, PS_TIMES: begin
                if (kind_reg == TK_INT) begin
                    shift_ok = 1'b1;
                    shift_st = PS_INT;
                end else if (kind_reg == TK_OPEN) begin
                    shift_ok = 1'b1;
                    shift_st = PS_OPEN;
                end
            end
            PS_EXPR: begin
                if (kind_reg == TK_PLUS) begin
                    shift_ok = 1'b1;
                    shift_st = PS_PLUS;
                end else if (kind_reg == TK_TIMES) begin
                    shift_ok = 1'b1;
                    shift_st = PS_TIMES;
                end else if (kind_reg == TK_END) begin
                    action = ACT_ACCEPT;
                end
            end
            PS_PAREN_EXPR: begin
                if (kind_reg == TK_PLUS) begin
                    shift_ok = 1'b1;
                    shift_st = PS_PLUS;
                end else if (kind_reg == TK_TIMES) begin
                    shift_ok = 1'b1;
                    shift_st = PS_TIMES;
                end else if (kind_reg == TK_CLOSE) begin
                    shift_ok = 1'b1;
                    shift_st = PS_CLOSE;
                end
            end
            PS_INT: begin
                reduce_ok = ops_kind && (top_reg != '0);
            end
            PS_SUM: begin
                if (kind_reg == TK_TIMES) begin
                    shift_ok = 1'b1;
                    shift_st = PS_TIMES;
                end else begin
                    reduce_ok = ops_kind && (top_reg >= PTR_THR);
                end
            end
            PS_PROD, PS_CLOSE: begin
                reduce_ok = ops_kind && (top_reg >= PTR_THR);
            end
            default: begin
                reduce_ok = 1'b0;
            end
        endcase
        if (shift_ok) begin
            action = (top_reg == TOP_MAX) ? ACT_OVERFLOW : ACT_SHIFT;
        end else if (reduce_ok) begin
            action = ACT_REDUCE;
        end
    end

    // Read addresses for a reduction
    always_comb begin
        if (tstate_reg == PS_INT) begin
            saddr = top_reg - PTR_ONE;
            vaddr = top_reg;
        end else if (tstate_reg == PS_CLOSE) begin
            saddr = top_reg - PTR_THR;
            vaddr = top_reg - PTR_ONE;
        end else begin
            saddr = top_reg - PTR_THR;
            vaddr = top_reg - PTR_TWO;
        end
    end

    // Reduce value and goto on the exposed state
    always_comb begin
        case (op_reg)
            PS_SUM:   rval = vrd_reg + topval_reg;
            PS_PROD:  rval = 32'(vrd_reg * topval_reg);
            PS_CLOSE: rval = vrd_reg;
            default:  rval = topval_reg;
        endcase
        exposed_st = sbot_reg ? PS_START : srd_reg;
        goto_bad   = 1'b0;
        case (exposed_st)
            PS_START: goto_st = PS_EXPR;
            PS_OPEN:  goto_st = PS_PAREN_EXPR;
            PS_PLUS:  goto_st = PS_SUM;
            PS_TIMES: goto_st = PS_PROD;
            default: begin
                goto_st  = PS_START;
                goto_bad = 1'b1;
            end
        endcase
    end

    // Stack write port: shift pushes, reduction replaces the handle
    always_comb begin
        mem_we = cmd.shift || cmd.write;
        if (cmd.shift) begin
            waddr  = top_reg + PTR_ONE;
            wstate = shift_st;
            wvalue = (kind_reg == TK_INT) ? tval_reg : 32'd0;
        end else begin
            waddr  = ntop_reg;
            wstate = goto_reg;
            wvalue = rval_reg;
        end
    end

    // Stack memories
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            state_mem[waddr] <= wstate;
            value_mem[waddr] <= wvalue;
        end
        if (cmd.read) begin
            srd_reg <= state_mem[saddr];
            vrd_reg <= value_mem[vaddr];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg       <= '0;
            tstate_reg    <= PS_START;
            topval_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.finish) begin
                top_reg    <= '0;
                tstate_reg <= PS_START;
                topval_reg <= '0;
            end else if (cmd.shift) begin
                top_reg    <= waddr;
                tstate_reg <= wstate;
                topval_reg <= wvalue;
            end else if (cmd.write) begin
                top_reg    <= ntop_reg;
                tstate_reg <= goto_reg;
                topval_reg <= rval_reg;
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_data.token_kind;
            tval_reg <= s_data.token_value;
        end
        if (cmd.read) begin
            op_reg    <= tstate_reg;
            sbot_reg  <= (saddr == '0);
            saddr_reg <= saddr;
        end
        if (cmd.exec) begin
            rval_reg <= rval;
            goto_reg <= goto_st;
            gerr_reg <= goto_bad;
            ntop_reg <= saddr_reg + PTR_ONE;
        end
        if (cmd.finish) begin
            out_data_reg.status     <= cmd.fin_status;
            out_data_reg.expr_value <= (cmd.fin_status == ST_OK) ? topval_reg : 32'd0;
        end
    end

    assign status.action   = action;
    assign status.goto_err = gerr_reg;
    assign status.out_free = !out_valid_reg || m_ready;
    assign m_valid         = out_valid_reg;
    assign m_data          = out_data_reg;

endmodule

`default_nettype wire

### hdl/lr_expression_evaluator.sv
// Top level of the LR expression evaluator.
//
// Tokens enter on the s_ channel (s_valid/s_ready, payload s_data of type token_t),
// one request per token. Results leave on the m_ channel (m_valid/m_ready, payload
// m_data of type result_t): one result per expression, on the end token, on the
// first rejected token (syntax error) or on a shift into a full stack (overflow).
// Tokens that cause no result produce nothing on m_.
// A token that is shifted is taken in the idle state and shifted in the decide state; each
// reduction it triggers adds a stack read, a reduce/multiply and a stack write. A result is
// registered and shows on m_ in the cycle after the decision. The token rate is set by the
// single-port stack memories and the sequencer that walks one table step at a time.
// After reset the stack holds only the start state and no result is pending. A
// stalled receiver holds the result in the output register; the next token is
// still taken and parsed, and the block waits only when it needs to post a new
// result while the old one is not yet taken. After any result the stack clears.
`default_nettype none

module lr_expression_evaluator
    import lree_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire token_t  s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    lree_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lree_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

### hdl/lree_checker.sv
// Port-level assertions for the LR expression evaluator and their bind.
`default_nettype none

module lree_checker
    import lree_pkg::*;
(
    input wire logic    aclk,
    input wire logic    aresetn,
    input wire logic    s_valid,
    input wire logic    s_ready,
    input wire token_t  s_data,
    input wire logic    m_valid,
    input wire logic    m_ready,
    input wire result_t m_data
);

    // No result pending right after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Status is one of the three codes
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_OK) || (m_data.status == ST_SYNTAX) ||
                    (m_data.status == ST_OVERFLOW))
        else $error("bad status code");

    // Error results carry a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_OK) |-> m_data.expr_value == 32'sd0)
        else $error("error result with nonzero value");

    // One token at a time: ready drops after each accepted request
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("token accepted while previous still in work");

endmodule

bind lr_expression_evaluator lree_checker u_lree_checker (.*);

`default_nettype wire

### dv/tb_lr_expression_evaluator.sv
// Self-checking testbench for the LR expression evaluator: token requests in, results checked.
`timescale 1ns / 1ps

module tb_lr_expression_evaluator;
    import lree_pkg::*;

    // Token kinds that the parse table never accepts
    localparam logic [2:0] TK_BAD6 = 3'd6;
    localparam logic [2:0] TK_BAD7 = 3'd7;

    localparam int RANDOM_ITEMS = 700;
    localparam int CALM_ITEMS   = 100;
    localparam int STALL_CYCLES = 300;
    localparam int DRAIN_CYCLES = 200;
    localparam int WATCHDOG_MAX = 4000;

    typedef struct {
        token_t tok;
        bit     hold;   // wait for all results before offering this token
    } tok_req_t;

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    token_t  s_data  = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    result_t m_data;

    tok_req_t    token_q[$];
    result_t     expr_result_q[$];
    bit          hold_next = 1'b0;
    bit          calm_phase = 1'b0;
    int          mismatch_cnt = 0;
    int          results_seen = 0;
    int          idle_cycles = 0;

    // Parser state mirrored by the predictor
    logic [3:0]  stk_state[STACK_DEPTH];
    logic [31:0] stk_val[STACK_DEPTH];
    int unsigned stk_top;

    lr_expression_evaluator u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic void clear_parse_stack();
        stk_top      = 0;
        stk_state[0] = PS_START;
        stk_val[0]   = '0;
    endfunction

    // Runs the shift-reduce table for one token; returns 1 when a result is due
    function automatic bit eval_token(input token_t tok, output result_t res);
        logic [2:0]  kind;
        logic [31:0] lit;
        logic [3:0]  st;
        logic [3:0]  nxt_st;
        logic [3:0]  goto_st;
        logic [31:0] rval;
        int unsigned top;
        int unsigned pop;
        bit          do_shift;
        bit          goto_ok;
        bit          stop;
        bit          produced;
        kind     = tok.token_kind;
        lit      = tok.token_value;
        res      = '0;
        produced = 1'b0;
        stop     = 1'b0;
        while (!stop) begin
            do_shift = 1'b0;
            nxt_st   = PS_START;
            pop      = 0;
            rval     = '0;
            top      = stk_top;
            st       = stk_state[top];
            case (st)
                PS_START, PS_OPEN, PS_PLUS, PS_TIMES: begin
                    if (kind == TK_INT) begin
                        do_shift = 1'b1;
                        nxt_st   = PS_INT;
                    end else if (kind == TK_OPEN) begin
                        do_shift = 1'b1;
                        nxt_st   = PS_OPEN;
                    end
                end
                PS_EXPR: begin
                    if (kind == TK_PLUS) begin
                        do_shift = 1'b1;
                        nxt_st   = PS_PLUS;
                    end else if (kind == TK_TIMES) begin
                        do_shift = 1'b1;
                        nxt_st   = PS_TIMES;
                    end else if (kind == TK_END) begin
                        res.status     = ST_OK;
                        res.expr_value = stk_val[top];
                        produced       = 1'b1;
                    end
                end
                PS_PAREN_EXPR: begin
                    if (kind == TK_PLUS) begin
                        do_shift = 1'b1;
                        nxt_st   = PS_PLUS;
                    end else if (kind == TK_TIMES) begin
                        do_shift = 1'b1;
                        nxt_st   = PS_TIMES;
                    end else if (kind == TK_CLOSE) begin
                        do_shift = 1'b1;
                        nxt_st   = PS_CLOSE;
                    end
                end
                PS_INT: begin
                    if (kind == TK_PLUS || kind == TK_TIMES || kind == TK_CLOSE
                        || kind == TK_END) begin
                        pop  = 1;
                        rval = stk_val[top];
                    end
                end
                PS_SUM: begin
                    if (kind == TK_TIMES) begin
                        do_shift = 1'b1;
                        nxt_st   = PS_TIMES;
                    end else if ((kind == TK_PLUS || kind == TK_CLOSE || kind == TK_END)
                                 && top >= 3) begin
                        pop  = 3;
                        rval = stk_val[top-2] + stk_val[top];
                    end
                end
                PS_PROD, PS_CLOSE: begin
                    if ((kind == TK_PLUS || kind == TK_TIMES || kind == TK_CLOSE
                         || kind == TK_END) && top >= 3) begin
                        pop  = 3;
                        rval = (st == PS_PROD) ? stk_val[top-2] * stk_val[top]
                                               : stk_val[top-1];
                    end
                end
                default: ;
            endcase

            if (produced) begin
                stop = 1'b1;
            end else if (do_shift) begin
                // Shift, or flag overflow when the stack is full
                if (top + 1 >= STACK_DEPTH) begin
                    res.status = ST_OVERFLOW;
                    produced   = 1'b1;
                end else begin
                    stk_top            = top + 1;
                    stk_state[top + 1] = nxt_st;
                    stk_val[top + 1]   = (kind == TK_INT) ? lit : '0;
                end
                stop = 1'b1;
            end else if (pop != 0 && top >= pop) begin
                // Reduce, then goto on E from the exposed state
                top     = top - pop;
                goto_ok = 1'b1;
                goto_st = PS_START;
                case (stk_state[top])
                    PS_START: goto_st = PS_EXPR;
                    PS_OPEN:  goto_st = PS_PAREN_EXPR;
                    PS_PLUS:  goto_st = PS_SUM;
                    PS_TIMES: goto_st = PS_PROD;
                    default:  goto_ok = 1'b0;
                endcase
                if (!goto_ok) begin
                    res.status = ST_SYNTAX;
                    produced   = 1'b1;
                    stop       = 1'b1;
                end else begin
                    top            = top + 1;
                    stk_state[top] = goto_st;
                    stk_val[top]   = rval;
                    stk_top        = top;
                end
            end else begin
                res.status = ST_SYNTAX;
                produced   = 1'b1;
                stop       = 1'b1;
            end
        end
        if (produced) clear_parse_stack();
        return produced;
    endfunction

    // Stimulus construction
    task automatic push_tok(input logic [2:0] kind, input logic [31:0] val);
        tok_req_t r;
        r.tok.token_kind  = kind;
        r.tok.token_value = val;
        r.hold            = hold_next;
        hold_next         = 1'b0;
        token_q.push_back(r);
    endtask

    function automatic logic [31:0] rand_literal();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 9);
            1:       return -$urandom_range(0, 9);
            2:       return 32'h7fff_ffff;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic gen_factor(input int depth);
        if (depth < 3 && $urandom_range(0, 3) == 0) begin
            push_tok(TK_OPEN, $urandom);
            gen_expr(depth + 1);
            push_tok(TK_CLOSE, $urandom);
        end else begin
            push_tok(TK_INT, rand_literal());
        end
    endtask

    task automatic gen_term(input int depth);
        int n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            if (i > 0) push_tok(TK_TIMES, $urandom);
            gen_factor(depth);
        end
    endtask

    task automatic gen_expr(input int depth);
        int n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            if (i > 0) push_tok(TK_PLUS, $urandom);
            gen_term(depth);
        end
    endtask

    // Token driver
    always @(posedge aclk) begin
        logic   nxt_valid;
        token_t nxt_data;
        result_t res;
        int     gap_cnt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
            gap_cnt = 0;
        end else begin
            nxt_valid = s_valid;
            nxt_data  = s_data;
            if (s_valid && s_ready) begin
                if (eval_token(s_data, res)) expr_result_q.push_back(res);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else if (token_q.size() != 0
                             && !(token_q[0].hold && expr_result_q.size() != 0)) begin
                    if (!calm_phase && $urandom_range(0, 5) == 0) begin
                        gap_cnt = $urandom_range(0, 4);
                    end else begin
                        nxt_valid = 1'b1;
                        nxt_data  = token_q[0].tok;
                        token_q.pop_front();
                    end
                end
            end
            s_valid    <= nxt_valid;
            s_data     <= nxt_data;
            calm_phase <= (token_q.size() < CALM_ITEMS);
        end
    end

    // Result monitor and receiver backpressure
    always @(posedge aclk) begin
        result_t want;
        logic    nxt_ready;
        int      hold_cnt;
        bit      long_done;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_cnt  = 0;
            long_done = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expr_result_q.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("unexpected result: status %0d value %0d",
                                 m_data.status, m_data.expr_value);
                    mismatch_cnt++;
                end else begin
                    want = expr_result_q.pop_front();
                    if (m_data.status !== want.status
                        || m_data.expr_value !== want.expr_value) begin
                        if (mismatch_cnt < 10)
                            $display("result %0d: status exp %0d got %0d, value exp %0d got %0d",
                                     results_seen, want.status, m_data.status,
                                     want.expr_value, m_data.expr_value);
                        mismatch_cnt++;
                    end
                end
            end
            // One long hold-off to fill the block, short random bursts otherwise
            if (hold_cnt > 0) begin
                hold_cnt--;
                nxt_ready = 1'b0;
            end else if (results_seen >= 40 && !long_done) begin
                long_done = 1'b1;
                hold_cnt  = STALL_CYCLES;
                nxt_ready = 1'b0;
            end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
                hold_cnt  = $urandom_range(0, 4);
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
            m_ready <= nxt_ready;
        end
    end

    // Watchdog on cycles with no request accepted on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_MAX) begin
                $display("lr_expression_evaluator regression: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int  n_dir;
        int  start_idx;
        int  depth;
        int  idx;
        bit  hold_armed;
        clear_parse_stack();
        hold_armed = 1'b0;

        // Directed: wrap on sum and product, precedence with parens
        push_tok(TK_INT, 32'h7fff_ffff);
        push_tok(TK_PLUS, '0);
        push_tok(TK_INT, 32'd1);
        push_tok(TK_END, '0);
        push_tok(TK_INT, 32'h8000_0000);
        push_tok(TK_TIMES, '0);
        push_tok(TK_INT, 32'hffff_ffff);
        push_tok(TK_END, '0);
        push_tok(TK_OPEN, '0);
        push_tok(TK_INT, 32'd2);
        push_tok(TK_PLUS, '0);
        push_tok(TK_INT, 32'd3);
        push_tok(TK_CLOSE, '0);
        push_tok(TK_TIMES, '0);
        push_tok(TK_INT, 32'd4);
        push_tok(TK_PLUS, '0);
        push_tok(TK_INT, 32'd5);
        push_tok(TK_TIMES, '0);
        push_tok(TK_INT, 32'd6);
        push_tok(TK_END, '0);
        // Rejected tokens: operator at start, unknown kinds, bare end
        push_tok(TK_PLUS, '1);
        push_tok(TK_BAD6, '0);
        push_tok(TK_INT, 32'd9);
        push_tok(TK_BAD7, '1);
        push_tok(TK_END, '0);
        // Stack overflow on nested open parens
        repeat (STACK_DEPTH) push_tok(TK_OPEN, '0);
        push_tok(TK_END, '0);
        n_dir = token_q.size();

        // Random: mostly well-formed expressions, some broken, some noise
        while (token_q.size() < n_dir + RANDOM_ITEMS) begin
            if (!hold_armed && token_q.size() >= n_dir + RANDOM_ITEMS / 2) begin
                hold_next  = 1'b1;
                hold_armed = 1'b1;
            end
            start_idx = token_q.size();
            case ($urandom_range(0, 19))
                0: begin
                    repeat ($urandom_range(1, 4))
                        push_tok(3'($urandom_range(TK_INT, TK_BAD7)), $urandom);
                end
                1: begin
                    depth = $urandom_range(STACK_DEPTH - 6, STACK_DEPTH + 1);
                    repeat (depth) push_tok(TK_OPEN, $urandom);
                    push_tok(TK_INT, rand_literal());
                    repeat (depth) push_tok(TK_CLOSE, $urandom);
                    push_tok(TK_END, $urandom);
                end
                2, 3, 4: begin
                    gen_expr(0);
                    push_tok(TK_END, $urandom);
                    idx = $urandom_range(start_idx, token_q.size() - 1);
                    token_q[idx].tok.token_kind = 3'($urandom_range(TK_INT, TK_BAD7));
                end
                default: begin
                    gen_expr(0);
                    push_tok(TK_END, $urandom);
                end
            endcase
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain: all tokens taken, all results back, then let the block settle
        while (token_q.size() != 0 || s_valid) @(posedge aclk);
        while (expr_result_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_cnt == 0) begin
            $display("lr_expression_evaluator regression: pass");
        end else begin
            $display("lr_expression_evaluator regression: fail");
        end
        $finish;
    end

endmodule
